// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the chunked body decoder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/hcbd_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbd_pkg
// Constants, phase codes and helpers for the chunked body decoder.
// ---------------------------------------------------------------------------
package hcbd_pkg;

   localparam int SIZE_WIDTH_DEF = 32;
   localparam int COUNT_WIDTH    = 32;
   localparam int PHASE_WIDTH    = 4;

   localparam logic [COUNT_WIDTH-1:0] MAX_BODY_RESET = '1;

   localparam logic [PHASE_WIDTH-1:0] PH_SIZE     = 4'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_EXT      = 4'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_SIZE_LF  = 4'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_DATA     = 4'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_DATA_CR  = 4'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_DATA_LF  = 4'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_TRAILER  = 4'd6;
   localparam logic [PHASE_WIDTH-1:0] PH_FINAL_LF = 4'd7;
   localparam logic [PHASE_WIDTH-1:0] PH_DONE     = 4'd8;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam int ERR_TOO_LARGE = 0;
   localparam int ERR_SIZE_OVF  = 1;

   typedef struct packed {
      logic                   payload_valid;
      logic [7:0]             out_byte;
      logic                   body_done;
      logic                   too_large;
      logic                   size_overflow;
      logic [PHASE_WIDTH-1:0] phase;
   } rsp_payload_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] b);
      hex_digit_type r;
      r.is_hex = 1'b1;
      r.value  = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r.value = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         r.value = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         r.value = 4'(b - 8'h37);
      end else begin
         r.is_hex = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== sv/hcbd_ifs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbd channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ---------------------------------------------------------------------------
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       start_body;

   modport source (output valid, output in_byte, output start_body, input ready);
   modport sink   (input valid, input in_byte, input start_body, output ready);
endinterface

interface hcbd_rsp_if;
   import hcbd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   payload_valid;
   logic [7:0]             out_byte;
   logic                   body_done;
   logic                   too_large;
   logic                   size_overflow;
   logic [PHASE_WIDTH-1:0] phase;

   modport source (output valid, output payload_valid, output out_byte,
                   output body_done, output too_large, output size_overflow,
                   output phase, input ready);
   modport sink   (input valid, input payload_valid, input out_byte,
                   input body_done, input too_large, input size_overflow,
                   input phase, output ready);
endinterface

interface hcbd_csr_if;
   import hcbd_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [COUNT_WIDTH-1:0] max_body_bytes;

   modport source (output valid, output max_body_bytes, input ready);
   modport sink   (input valid, input max_body_bytes, output ready);
endinterface

// ===== sv/hcbd_in_reg.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// hcbd_in_reg
// Input register: captures one request, holds it until the parser steps.
// ---------------------------------------------------------------------------
module hcbd_in_reg (
   input  logic       clock,
   input  logic       reset,
   hcbd_req_if.sink   req_chan,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte,
   output logic       held_start
);
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;
   logic       take;

   assign req_chan.ready = !valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign valid_in       = take ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff  <= req_chan.in_byte;
         start_ff <= req_chan.start_body;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;
   assign held_start = start_ff;

   // a held request is never dropped without a step
   `ASSERT_NEXT(a_held_kept, clock, reset, valid_ff && !advance, valid_ff)
   `ASSERT_IMPLIES(a_step_needs_item, clock, reset, advance, valid_ff)

endmodule

// ===== sv/hcbd_parser.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// hcbd_parser
// Framing state and one-byte step of the chunked body parser.
// ---------------------------------------------------------------------------
module hcbd_parser #(
   parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [7:0]                          in_byte,
   input  logic                                start_body,
   input  logic [hcbd_pkg::COUNT_WIDTH-1:0]    max_body,
   output hcbd_pkg::rsp_payload_type           result
);
   import hcbd_pkg::*;

   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [SIZE_WIDTH-1:0]  accum_ff, accum_in;
   logic [SIZE_WIDTH-1:0]  left_ff, left_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [1:0]             err_ff, err_in;
   logic                   pv;
   hex_digit_type          hex;

   assign hex = hex_decode(in_byte);

   always_comb begin
      phase_in = start_body ? PH_SIZE : phase_ff;
      accum_in = start_body ? '0 : accum_ff;
      left_in  = start_body ? '0 : left_ff;
      count_in = start_body ? '0 : count_ff;
      err_in   = start_body ? '0 : err_ff;
      pv       = 1'b0;
      case (phase_in)
         PH_SIZE: begin
            if (hex.is_hex) begin
               if (accum_in[SIZE_WIDTH-1 -: 4] != 4'd0) begin
                  accum_in             = '1;
                  err_in[ERR_SIZE_OVF] = 1'b1;
               end else begin
                  accum_in = {accum_in[SIZE_WIDTH-5:0], hex.value};
               end
            end else if (in_byte == CH_CR) begin
               phase_in = PH_SIZE_LF;
            end else begin
               phase_in = PH_EXT;
            end
         end
         PH_EXT: begin
            if (in_byte == CH_CR) phase_in = PH_SIZE_LF;
         end
         PH_SIZE_LF: begin
            if (in_byte == CH_LF) begin
               if (accum_in == '0) begin
                  phase_in = PH_TRAILER;
               end else begin
                  left_in  = accum_in;
                  accum_in = '0;
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            if (left_in != '0) begin
               pv = 1'b1;
               if (count_in >= max_body) begin
                  err_in[ERR_TOO_LARGE] = 1'b1;
               end else begin
                  count_in = count_in + 1'b1;
               end
               left_in = left_in - 1'b1;
            end
            if (left_in == '0) phase_in = PH_DATA_CR;
         end
         PH_DATA_CR: begin
            if (in_byte == CH_CR) phase_in = PH_DATA_LF;
         end
         PH_DATA_LF: begin
            if (in_byte == CH_LF) begin
               phase_in = PH_SIZE;
               accum_in = '0;
            end
         end
         PH_TRAILER: begin
            if (in_byte == CH_CR) phase_in = PH_FINAL_LF;
         end
         PH_FINAL_LF: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         accum_ff <= '0;
         left_ff  <= '0;
         count_ff <= '0;
         err_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         left_ff  <= left_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   always_comb begin
      result.payload_valid = pv;
      result.out_byte      = pv ? in_byte : 8'd0;
      result.body_done     = (phase_in == PH_FINAL_LF) || (phase_in == PH_DONE);
      result.too_large     = err_in[ERR_TOO_LARGE];
      result.size_overflow = err_in[ERR_SIZE_OVF];
      result.phase         = phase_in;
   end

   // data phase always has bytes outstanding
   `ASSERT_IMPLIES(a_data_has_count, clock, reset, phase_ff == PH_DATA, left_ff != '0)
   `ASSERT_NEXT(a_too_large_sticky, clock, reset,
                err_ff[ERR_TOO_LARGE] && !(step && start_body), err_ff[ERR_TOO_LARGE])
   `ASSERT_NEXT(a_ovf_sticky, clock, reset,
                err_ff[ERR_SIZE_OVF] && !(step && start_body), err_ff[ERR_SIZE_OVF])

endmodule

// ===== sv/hcbd_out_reg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hcbd_out_reg
// Result register: holds one response until the receiver takes it.
// ---------------------------------------------------------------------------
module hcbd_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  hcbd_pkg::rsp_payload_type result,
   hcbd_rsp_if.source                rsp_chan
);
   import hcbd_pkg::*;

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff;

   assign valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.payload_valid = data_ff.payload_valid;
   assign rsp_chan.out_byte      = data_ff.out_byte;
   assign rsp_chan.body_done     = data_ff.body_done;
   assign rsp_chan.too_large     = data_ff.too_large;
   assign rsp_chan.size_overflow = data_ff.size_overflow;
   assign rsp_chan.phase         = data_ff.phase;

endmodule

// ===== sv/http_chunked_body_decoder_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_top
// Decodes an HTTP chunked body one raw byte per request.
// ---------------------------------------------------------------------------
// Usage:
//   req_chan carries one raw body byte per request; start_body set clears the
//   framing state before that byte is parsed. rsp_chan returns exactly one
//   response per request, in order: the payload byte when it lies in chunk
//   data, plus done, sticky error flags and the parse phase.
//   csr_chan writes max_body_bytes; it is always ready. The user must write it
//   only while no request is in flight; the block does not enforce this.
//   Path: a request accepted into the input register is stepped through the
//   parser once the result register is free or being taken, and its response
//   is then held in the result register until rsp_chan takes it.
//   Throughput: one request per cycle while rsp_chan does not stall, set by the
//   parser state update between the input and result registers.
//   Reset: framing state and flags clear, max_body_bytes returns to all ones.
//   Stall: a waiting response holds; one more request is taken into the input
//   register, then req_chan.ready drops until the response is taken.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder_top #(
   parameter int SIZE_WIDTH = hcbd_pkg::SIZE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hcbd_req_if.sink   req_chan,
   hcbd_rsp_if.source rsp_chan,
   hcbd_csr_if.sink   csr_chan
);
   import hcbd_pkg::*;

   logic                   held_valid;
   logic [7:0]             held_byte;
   logic                   held_start;
   logic                   advance;
   logic [COUNT_WIDTH-1:0] max_body_ff;
   rsp_payload_type        result;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_ff <= MAX_BODY_RESET;
      end else if (csr_chan.valid) begin
         max_body_ff <= csr_chan.max_body_bytes;
      end
   end

   assign advance = held_valid && (!rsp_chan.valid || rsp_chan.ready);

   hcbd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte),
      .held_start (held_start)
   );

   hcbd_parser #(
      .SIZE_WIDTH (SIZE_WIDTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .in_byte    (held_byte),
      .start_body (held_start),
      .max_body   (max_body_ff),
      .result     (result)
   );

   hcbd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result   (result),
      .rsp_chan (rsp_chan)
   );

endmodule
